@@ sv/grwa_pkg.sv @@
`timescale 1ns / 1ps
// grwa_pkg: widths, opcodes, state encoding and inter-module structs for the
// grid weight accumulator. No dependencies.

package grwa_pkg;

    localparam int unsigned OP_W     = 2;
    localparam int unsigned POS_W    = 11;
    localparam int unsigned SPAN_W   = 7;
    localparam int unsigned WGT_W    = 8;
    localparam int unsigned IDX_W    = 12;
    localparam int unsigned VAL_W    = 16;
    localparam int unsigned CNT_W    = 13;
    localparam int unsigned DEPTH    = 4096;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_STAMP = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        GK_READ,
        GK_RMW,
        GK_ZERO
    } t_gkind;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_DIVY_GO,
        ST_DIVY_WAIT,
        ST_MUL,
        ST_BASE,
        ST_WALK,
        ST_READ,
        ST_READ_WAIT,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             valid;
        t_gkind           kind;
        logic [IDX_W-1:0] addr;
        logic [WGT_W-1:0] weight;
    } t_grid_req;

    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] data;
    } t_grid_rsp;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] quot;
    } t_div_rsp;

endpackage

@@ sv/grwa_if.sv @@
`timescale 1ns / 1ps
// Command and result channels of the grid weight accumulator.
// Depends on grwa_pkg for field widths.

interface grwa_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [grwa_pkg::OP_W-1:0]     opcode;
    logic [grwa_pkg::POS_W-1:0]    pos_x;
    logic [grwa_pkg::POS_W-1:0]    pos_y;
    logic [grwa_pkg::SPAN_W-1:0]   span_cols;
    logic [grwa_pkg::SPAN_W-1:0]   span_rows;
    logic [grwa_pkg::WGT_W-1:0]    weight;
    logic [grwa_pkg::IDX_W-1:0]    cell_index;

    modport source (
        output valid, opcode, pos_x, pos_y, span_cols, span_rows, weight, cell_index,
        input  ready
    );
    modport sink (
        input  valid, opcode, pos_x, pos_y, span_cols, span_rows, weight, cell_index,
        output ready
    );
endinterface

interface grwa_res_if;
    logic                          valid;
    logic                          ready;
    logic [grwa_pkg::VAL_W-1:0]    cell_value;
    logic                          occupied;
    logic [grwa_pkg::CNT_W-1:0]    cells_touched;

    modport source (
        output valid, cell_value, occupied, cells_touched,
        input  ready
    );
    modport sink (
        input  valid, cell_value, occupied, cells_touched,
        output ready
    );
endinterface

@@ sv/grwa_div.sv @@
`timescale 1ns / 1ps
// grwa_div: pixel-to-cell divider by reciprocal multiplication, quotient ready the
// cycle after start. Depends on grwa_pkg. Serves both pixel-to-cell conversions.

module grwa_div #(
    parameter int unsigned DIVISOR = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [grwa_pkg::POS_W-1:0]    i_dividend,
    output grwa_pkg::t_div_rsp            o_rsp
);

    // floor(2^SHIFT / DIVISOR) + 1 gives an exact floor for every 11-bit dividend
    localparam int unsigned        SHIFT   = 2 * grwa_pkg::POS_W;
    localparam int unsigned        RECIP_W = SHIFT + 1;
    localparam int unsigned        PROD_W  = grwa_pkg::POS_W + RECIP_W;
    localparam longint unsigned    RECIP   = (64'd1 << SHIFT) / DIVISOR + 64'd1;
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

    logic                             r_done;
    logic [grwa_pkg::POS_W-1:0]       r_q;

    logic [PROD_W-1:0]                w_prod;

    always_comb begin
        w_prod = PROD_W'(i_dividend) * PROD_W'(RECIP_K);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= w_prod[SHIFT +: grwa_pkg::POS_W];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

@@ sv/grwa_grid.sv @@
`timescale 1ns / 1ps
// grwa_grid: weight cell store with a two-stage read-modify-write path and a
// saturating adder. Depends on grwa_pkg.

module grwa_grid (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  grwa_pkg::t_grid_req   i_req,
    output grwa_pkg::t_grid_rsp   o_rsp
);

    logic [grwa_pkg::VAL_W-1:0]   mem [grwa_pkg::DEPTH];

    grwa_pkg::t_grid_req          r_p;
    logic [grwa_pkg::VAL_W-1:0]   r_rd_data;
    logic                         r_w_valid;
    logic [grwa_pkg::IDX_W-1:0]   r_w_addr;
    logic [grwa_pkg::VAL_W-1:0]   r_w_data;

    logic [grwa_pkg::VAL_W-1:0]   w_cur;
    logic [grwa_pkg::VAL_W:0]     w_sum;
    logic                         n_w_en;
    logic [grwa_pkg::VAL_W-1:0]   n_w_data;

    // the word written last cycle was missed by the read issued alongside it
    always_comb begin
        w_cur = (r_w_valid && (r_w_addr == r_p.addr)) ? r_w_data : r_rd_data;
        w_sum = {1'b0, w_cur} + {{(grwa_pkg::VAL_W + 1 - grwa_pkg::WGT_W){1'b0}}, r_p.weight};
        n_w_en   = 1'b0;
        n_w_data = '0;
        case (r_p.kind)
            grwa_pkg::GK_RMW: begin
                n_w_en   = r_p.valid;
                n_w_data = w_sum[grwa_pkg::VAL_W] ? '1 : w_sum[grwa_pkg::VAL_W-1:0];
            end
            grwa_pkg::GK_ZERO: begin
                n_w_en   = r_p.valid;
                n_w_data = '0;
            end
            default: begin
                n_w_en   = 1'b0;
                n_w_data = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p       <= '0;
            r_w_valid <= 1'b0;
        end else begin
            r_p       <= i_req;
            r_w_valid <= n_w_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_req.addr];
        r_w_addr  <= r_p.addr;
        r_w_data  <= n_w_data;
        if (n_w_en) begin
            mem[r_p.addr] <= n_w_data;
        end
    end

    assign o_rsp.valid = r_p.valid && (r_p.kind == grwa_pkg::GK_READ);
    assign o_rsp.data  = w_cur;

endmodule

@@ sv/grid_rect_weight_accumulate_unit.sv @@
`timescale 1ns / 1ps
// Grid weight accumulator. A clear zeroes every active cell, a stamp adds its weight to
// each cell of its footprint, walked column by column, and a read fetches one cell (zero
// when the index is past the end). The result shows in the same cycle the block turns
// ready again; a result still waiting holds the block in its last state. After reset a
// clearing pass over GRID_COLS*GRID_ROWS cells (capped at 4096) zeroes the store; no
// word is accepted until it ends. Depends on grwa_pkg/if, grwa_div and grwa_grid.

module grid_rect_weight_accumulate_unit #(
    parameter int unsigned CELL_SIZE = 32,
    parameter int unsigned GRID_COLS = 64,
    parameter int unsigned GRID_ROWS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    grwa_cmd_if.sink   i_cmd,
    grwa_res_if.source o_res
);

    localparam int unsigned CELLS = GRID_COLS * GRID_ROWS;
    localparam int unsigned SIZE  = (CELLS > grwa_pkg::DEPTH) ? grwa_pkg::DEPTH : CELLS;
    // holds the largest start index plus column offset plus one row stride
    localparam int unsigned K_W   = grwa_pkg::POS_W + 1 + $clog2(GRID_COLS + 1);
    localparam logic [K_W-1:0] COLS_K = K_W'(GRID_COLS);
    localparam logic [K_W-1:0] SIZE_K = K_W'(SIZE);

    grwa_pkg::t_state               r_state, n_state;
    logic                           r_boot;
    logic [grwa_pkg::IDX_W-1:0]     r_clr;

    logic [grwa_pkg::POS_W-1:0]     r_pos_x, r_pos_y;
    logic [grwa_pkg::SPAN_W-1:0]    r_span_cols, r_span_rows;
    logic [grwa_pkg::WGT_W-1:0]     r_weight;
    logic [grwa_pkg::IDX_W-1:0]     r_cell_index;

    logic [grwa_pkg::POS_W-1:0]     r_qx, r_qy;
    logic [K_W-1:0]                 r_prod, r_base, r_k;
    logic [grwa_pkg::SPAN_W-1:0]    r_rows_left, r_cols_left;

    logic [grwa_pkg::VAL_W-1:0]     r_value;
    logic                           r_occ;
    logic [grwa_pkg::CNT_W-1:0]     r_touched;

    logic                           r_out_valid;
    logic [grwa_pkg::VAL_W-1:0]     r_out_value;
    logic                           r_out_occ;
    logic [grwa_pkg::CNT_W-1:0]     r_out_touched;

    grwa_pkg::t_grid_req            w_greq;
    grwa_pkg::t_grid_rsp            w_grsp;
    grwa_pkg::t_div_rsp             w_drsp;
    logic                           w_div_start;
    logic [grwa_pkg::POS_W-1:0]     w_div_in;

    logic w_accept, w_hit, w_col_out, w_last_col, w_clr_last, w_rd_in, w_out_free;

    always_comb begin
        w_accept   = i_cmd.valid && i_cmd.ready;
        w_hit      = (r_k < SIZE_K) && (r_rows_left != '0);
        // a column whose first cell is past the end ends the stamp: later ones start higher
        w_col_out  = (r_k >= SIZE_K) && (r_rows_left == r_span_rows);
        w_last_col = (r_cols_left == grwa_pkg::SPAN_W'(1));
        w_clr_last = (r_clr == grwa_pkg::IDX_W'(SIZE - 1));
        w_rd_in    = ({1'b0, r_cell_index} < grwa_pkg::CNT_W'(SIZE));
        w_out_free = !r_out_valid || o_res.ready;
    end

    grwa_div #(
        .DIVISOR (CELL_SIZE)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_in),
        .o_rsp      (w_drsp)
    );

    grwa_grid u_grid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_greq),
        .o_rsp   (w_grsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            grwa_pkg::ST_CLEAR:     if (w_clr_last) n_state = grwa_pkg::ST_DRAIN;
            grwa_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_cmd.opcode)
                        grwa_pkg::OP_CLEAR: n_state = grwa_pkg::ST_CLEAR;
                        grwa_pkg::OP_STAMP: n_state = grwa_pkg::ST_DIVX_GO;
                        grwa_pkg::OP_READ:  n_state = grwa_pkg::ST_READ;
                        default:            n_state = grwa_pkg::ST_DONE;
                    endcase
                end
            end
            grwa_pkg::ST_DIVX_GO:   n_state = grwa_pkg::ST_DIVX_WAIT;
            grwa_pkg::ST_DIVX_WAIT: if (w_drsp.done) n_state = grwa_pkg::ST_DIVY_GO;
            grwa_pkg::ST_DIVY_GO:   n_state = grwa_pkg::ST_DIVY_WAIT;
            grwa_pkg::ST_DIVY_WAIT: if (w_drsp.done) n_state = grwa_pkg::ST_MUL;
            grwa_pkg::ST_MUL:       n_state = grwa_pkg::ST_BASE;
            grwa_pkg::ST_BASE: begin
                if (r_span_cols == '0 || r_span_rows == '0) n_state = grwa_pkg::ST_DONE;
                else                                       n_state = grwa_pkg::ST_WALK;
            end
            grwa_pkg::ST_WALK: begin
                if (!w_hit && (w_col_out || w_last_col)) n_state = grwa_pkg::ST_DRAIN;
            end
            grwa_pkg::ST_READ: begin
                if (w_rd_in) n_state = grwa_pkg::ST_READ_WAIT;
                else         n_state = grwa_pkg::ST_DONE;
            end
            grwa_pkg::ST_READ_WAIT: if (w_grsp.valid) n_state = grwa_pkg::ST_DONE;
            grwa_pkg::ST_DRAIN: begin
                if (r_boot) n_state = grwa_pkg::ST_IDLE;
                else        n_state = grwa_pkg::ST_DONE;
            end
            grwa_pkg::ST_DONE:      if (w_out_free) n_state = grwa_pkg::ST_IDLE;
            default:                n_state = grwa_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_cmd.ready   = (r_state == grwa_pkg::ST_IDLE);
        w_div_start   = (r_state == grwa_pkg::ST_DIVX_GO) || (r_state == grwa_pkg::ST_DIVY_GO);
        w_div_in      = (r_state == grwa_pkg::ST_DIVX_GO) ? r_pos_x : r_pos_y;
        w_greq.valid  = 1'b0;
        w_greq.kind   = grwa_pkg::GK_READ;
        w_greq.addr   = r_k[grwa_pkg::IDX_W-1:0];
        w_greq.weight = r_weight;
        case (r_state)
            grwa_pkg::ST_CLEAR: begin
                w_greq.valid = 1'b1;
                w_greq.kind  = grwa_pkg::GK_ZERO;
                w_greq.addr  = r_clr;
            end
            grwa_pkg::ST_WALK: begin
                w_greq.valid = w_hit;
                w_greq.kind  = grwa_pkg::GK_RMW;
            end
            grwa_pkg::ST_READ: begin
                w_greq.valid = w_rd_in;
                w_greq.kind  = grwa_pkg::GK_READ;
                w_greq.addr  = r_cell_index;
            end
            default: begin
                w_greq.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= grwa_pkg::ST_CLEAR;
            r_boot      <= 1'b1;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == grwa_pkg::ST_DRAIN) begin
                r_boot <= 1'b0;
            end
            if (r_state == grwa_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end else begin
                r_clr <= '0;
            end
            if (r_state == grwa_pkg::ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            grwa_pkg::ST_IDLE: begin
                r_pos_x      <= i_cmd.pos_x;
                r_pos_y      <= i_cmd.pos_y;
                r_span_cols  <= i_cmd.span_cols;
                r_span_rows  <= i_cmd.span_rows;
                r_weight     <= i_cmd.weight;
                r_cell_index <= i_cmd.cell_index;
                r_value      <= '0;
                r_occ        <= 1'b0;
                r_touched    <= '0;
            end
            grwa_pkg::ST_CLEAR: begin
                r_touched <= grwa_pkg::CNT_W'(SIZE);
            end
            grwa_pkg::ST_DIVX_WAIT: if (w_drsp.done) r_qx <= w_drsp.quot;
            grwa_pkg::ST_DIVY_WAIT: if (w_drsp.done) r_qy <= w_drsp.quot;
            grwa_pkg::ST_MUL: begin
                r_prod <= K_W'(r_qy) * COLS_K;
            end
            grwa_pkg::ST_BASE: begin
                r_base      <= r_prod + K_W'(r_qx);
                r_k         <= r_prod + K_W'(r_qx);
                r_rows_left <= r_span_rows;
                r_cols_left <= r_span_cols;
            end
            grwa_pkg::ST_WALK: begin
                if (w_hit) begin
                    r_k         <= r_k + COLS_K;
                    r_rows_left <= r_rows_left - 1'b1;
                    r_touched   <= r_touched + 1'b1;
                end else if (!w_col_out && !w_last_col) begin
                    // columns past the right edge simply run on into the next row
                    r_base      <= r_base + 1'b1;
                    r_k         <= r_base + 1'b1;
                    r_rows_left <= r_span_rows;
                    r_cols_left <= r_cols_left - 1'b1;
                end
            end
            grwa_pkg::ST_READ_WAIT: begin
                if (w_grsp.valid) begin
                    r_value <= w_grsp.data;
                    r_occ   <= |w_grsp.data;
                end
            end
            grwa_pkg::ST_DONE: begin
                if (w_out_free) begin
                    r_out_value   <= r_value;
                    r_out_occ     <= r_occ;
                    r_out_touched <= r_touched;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.cell_value    = r_out_value;
    assign o_res.occupied      = r_out_occ;
    assign o_res.cells_touched = r_out_touched;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for grid_rect_weight_accumulate_unit: drives clear, stamp and read
// words and checks every result against a cell-accurate predictor of the weight grid.
// Depends on grwa_pkg and the grwa_cmd_if / grwa_res_if channels.

module tb;

    localparam int unsigned CELL_SIZE    = 32;
    localparam int unsigned GRID_COLS    = 64;
    localparam int unsigned GRID_ROWS    = 64;
    localparam int unsigned ACTIVE_CELLS =
        (GRID_COLS * GRID_ROWS > grwa_pkg::DEPTH) ? grwa_pkg::DEPTH : GRID_COLS * GRID_ROWS;
    localparam int unsigned RANDOM_WORDS = 112;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam longint unsigned TIMEOUT_NS = 64'd20_000_000;

    typedef struct packed {
        grwa_pkg::t_op                op;
        logic [grwa_pkg::POS_W-1:0]   pos_x;
        logic [grwa_pkg::POS_W-1:0]   pos_y;
        logic [grwa_pkg::SPAN_W-1:0]  span_cols;
        logic [grwa_pkg::SPAN_W-1:0]  span_rows;
        logic [grwa_pkg::WGT_W-1:0]   weight;
        logic [grwa_pkg::IDX_W-1:0]   cell_index;
    } t_grid_cmd;

    typedef struct packed {
        logic [grwa_pkg::VAL_W-1:0]   cell_value;
        logic                         occupied;
        logic [grwa_pkg::CNT_W-1:0]   cells_touched;
    } t_grid_result;

    // Keeps its own copy of the grid; one expected result per accepted word.
    class t_grid_weight_scoreboard;
        bit [grwa_pkg::VAL_W-1:0] cells [grwa_pkg::DEPTH];
        t_grid_result   expected_q [$];
        int unsigned    mismatches;
        int unsigned    results_checked;
        int unsigned    clears, stamps, reads;
        int unsigned    spilled_stamps, clipped_stamps, saturated_reads;

        function void note_command(t_grid_cmd c);
            t_grid_result r;
            int unsigned  start, col0, row0, i, j, k, sum, touched;
            bit           clipped;
            r = '0;
            touched = 0;
            clipped = 1'b0;
            case (c.op)
                grwa_pkg::OP_CLEAR: begin
                    foreach (cells[n]) cells[n] = '0;
                    r.cells_touched = grwa_pkg::CNT_W'(ACTIVE_CELLS);
                    clears++;
                end
                grwa_pkg::OP_STAMP: begin
                    start = (c.pos_y / CELL_SIZE) * GRID_COLS + c.pos_x / CELL_SIZE;
                    col0  = start % GRID_COLS;
                    row0  = start / GRID_COLS;
                    // columns walk on past the right edge into the rows below
                    for (i = col0; i < col0 + c.span_cols; i++) begin
                        for (j = row0; j < row0 + c.span_rows; j++) begin
                            k = j * GRID_COLS + i;
                            if (k >= ACTIVE_CELLS) begin
                                clipped = 1'b1;
                                break;
                            end
                            sum = cells[k] + c.weight;
                            cells[k] = (sum > 32'hFFFF) ? 16'hFFFF : 16'(sum);
                            touched++;
                        end
                    end
                    r.cells_touched = grwa_pkg::CNT_W'(touched);
                    stamps++;
                    if (col0 + c.span_cols > GRID_COLS && c.span_rows != 0)
                        spilled_stamps++;
                    if (clipped)
                        clipped_stamps++;
                end
                grwa_pkg::OP_READ: begin
                    if (c.cell_index < ACTIVE_CELLS) begin
                        r.cell_value = cells[c.cell_index];
                        r.occupied   = (cells[c.cell_index] != 0);
                    end
                    if (r.cell_value == 16'hFFFF)
                        saturated_reads++;
                    reads++;
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_result(t_grid_result got);
            t_grid_result exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no word outstanding: value %0d occ %0d touched %0d",
                         $time, got.cell_value, got.occupied, got.cells_touched);
                mismatches++;
                return;
            end
            exp_res = expected_q.pop_front();
            results_checked++;
            if (got.cell_value !== exp_res.cell_value) begin
                $display("%0t: cell_value expected %0d actual %0d",
                         $time, exp_res.cell_value, got.cell_value);
                mismatches++;
            end
            if (got.occupied !== exp_res.occupied) begin
                $display("%0t: occupied expected %0d actual %0d",
                         $time, exp_res.occupied, got.occupied);
                mismatches++;
            end
            if (got.cells_touched !== exp_res.cells_touched) begin
                $display("%0t: cells_touched expected %0d actual %0d",
                         $time, exp_res.cells_touched, got.cells_touched);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    grwa_cmd_if cmd_bus ();
    grwa_res_if res_bus ();

    grid_rect_weight_accumulate_unit #(
        .CELL_SIZE (CELL_SIZE),
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    t_grid_weight_scoreboard grid_sb = new();
    int unsigned hot_cells [$];     // start cells of recent stamps, for reads that hit
    int unsigned hold_request;      // long receiver hold-off, taken up by the sink process
    bit          no_idle;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("grid_rect_weight_accumulate_unit test failed");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 15);
        else
            return $urandom_range(30, 120);
    endfunction

    function automatic t_grid_cmd make_stamp(int unsigned x, int unsigned y, int unsigned sc,
                                             int unsigned sr, int unsigned w);
        t_grid_cmd c;
        c = '0;
        c.op        = grwa_pkg::OP_STAMP;
        c.pos_x     = grwa_pkg::POS_W'(x);
        c.pos_y     = grwa_pkg::POS_W'(y);
        c.span_cols = grwa_pkg::SPAN_W'(sc);
        c.span_rows = grwa_pkg::SPAN_W'(sr);
        c.weight    = grwa_pkg::WGT_W'(w);
        return c;
    endfunction

    function automatic t_grid_cmd make_read(int unsigned idx);
        t_grid_cmd c;
        c = '0;
        c.op         = grwa_pkg::OP_READ;
        c.cell_index = grwa_pkg::IDX_W'(idx);
        return c;
    endfunction

    function automatic t_grid_cmd make_clear();
        t_grid_cmd c;
        c = '0;
        c.op = grwa_pkg::OP_CLEAR;
        return c;
    endfunction

    // Mostly small stamps and reads near earlier stamps; clears and big footprints are rare.
    function automatic t_grid_cmd random_command();
        t_grid_cmd   c;
        int unsigned r, col, row;
        c.op         = grwa_pkg::OP_READ;
        c.pos_x      = grwa_pkg::POS_W'($urandom_range(0, 2047));
        c.pos_y      = grwa_pkg::POS_W'($urandom_range(0, 2047));
        c.span_cols  = grwa_pkg::SPAN_W'($urandom_range(0, 64));
        c.span_rows  = grwa_pkg::SPAN_W'($urandom_range(0, 64));
        c.weight     = grwa_pkg::WGT_W'($urandom_range(0, 255));
        c.cell_index = grwa_pkg::IDX_W'($urandom_range(0, grwa_pkg::DEPTH - 1));
        col = ($urandom_range(0, 4) == 0) ? $urandom_range(GRID_COLS - 8, GRID_COLS - 1)
                                          : $urandom_range(0, GRID_COLS - 1);
        row = ($urandom_range(0, 4) == 0) ? $urandom_range(GRID_ROWS - 8, GRID_ROWS - 1)
                                          : $urandom_range(0, GRID_ROWS - 1);
        r = $urandom_range(0, 99);
        if (r < 3) begin
            c.op = grwa_pkg::OP_CLEAR;
        end else if (r < 58) begin
            c.op    = grwa_pkg::OP_STAMP;
            c.pos_x = grwa_pkg::POS_W'(col * CELL_SIZE + $urandom_range(0, CELL_SIZE - 1));
            c.pos_y = grwa_pkg::POS_W'(row * CELL_SIZE + $urandom_range(0, CELL_SIZE - 1));
            if ($urandom_range(0, 99) < 4) begin
                c.span_cols = grwa_pkg::SPAN_W'($urandom_range(32, 64));
                c.span_rows = grwa_pkg::SPAN_W'($urandom_range(32, 64));
            end else begin
                c.span_cols = grwa_pkg::SPAN_W'($urandom_range(0, 6));
                c.span_rows = grwa_pkg::SPAN_W'($urandom_range(0, 6));
            end
            if ($urandom_range(0, 7) == 0)
                c.weight = '1;
            hot_cells.push_back(row * GRID_COLS + col);
            if (hot_cells.size() > 16)
                void'(hot_cells.pop_front());
        end else if (hot_cells.size() != 0 && $urandom_range(0, 3) != 0) begin
            c.cell_index = grwa_pkg::IDX_W'((hot_cells[$urandom_range(0, hot_cells.size() - 1)]
                                             + $urandom_range(0, 2) * GRID_COLS
                                             + $urandom_range(0, 2)) % grwa_pkg::DEPTH);
        end
        return c;
    endfunction

    task automatic send_command(input t_grid_cmd c, input int unsigned gap);
        if (gap != 0) begin
            @(negedge i_clk);
            cmd_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        cmd_bus.valid      <= 1'b1;
        cmd_bus.opcode     <= c.op;
        cmd_bus.pos_x      <= c.pos_x;
        cmd_bus.pos_y      <= c.pos_y;
        cmd_bus.span_cols  <= c.span_cols;
        cmd_bus.span_rows  <= c.span_rows;
        cmd_bus.weight     <= c.weight;
        cmd_bus.cell_index <= c.cell_index;
        do @(posedge i_clk); while (!cmd_bus.ready);
    endtask

    task automatic send_random_words(input int unsigned count);
        int unsigned n;
        for (n = 0; n < count; n++)
            send_command(random_command(), no_idle ? 0 : pick_gap());
    endtask

    // Result sink: random stalls, plus a long hold-off when one is requested.
    initial begin
        int unsigned hold_left;
        int unsigned stall_left;
        hold_left  = 0;
        stall_left = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : word_monitor
        t_grid_cmd    seen_cmd;
        t_grid_result seen_res;
        if (i_rst_n) begin
            if (res_bus.valid && res_bus.ready) begin
                seen_res.cell_value    = res_bus.cell_value;
                seen_res.occupied      = res_bus.occupied;
                seen_res.cells_touched = res_bus.cells_touched;
                grid_sb.check_result(seen_res);
            end
            if (cmd_bus.valid && cmd_bus.ready) begin
                seen_cmd.op         = grwa_pkg::t_op'(cmd_bus.opcode);
                seen_cmd.pos_x      = cmd_bus.pos_x;
                seen_cmd.pos_y      = cmd_bus.pos_y;
                seen_cmd.span_cols  = cmd_bus.span_cols;
                seen_cmd.span_rows  = cmd_bus.span_rows;
                seen_cmd.weight     = cmd_bus.weight;
                seen_cmd.cell_index = cmd_bus.cell_index;
                grid_sb.note_command(seen_cmd);
            end
        end
    end

    initial begin
        int unsigned n;
        hold_request       = 0;
        no_idle            = 1'b0;
        i_rst_n            = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.opcode     = grwa_pkg::OP_CLEAR;
        cmd_bus.pos_x      = '0;
        cmd_bus.pos_y      = '0;
        cmd_bus.span_cols  = '0;
        cmd_bus.span_rows  = '0;
        cmd_bus.weight     = '0;
        cmd_bus.cell_index = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corners, spill past the right edge, end-of-grid skip, empty spans
        send_command(make_read(0), pick_gap());
        send_command(make_read(grwa_pkg::DEPTH - 1), pick_gap());
        send_command(make_stamp(0, 0, 1, 1, 255), pick_gap());
        send_command(make_read(0), pick_gap());
        send_command(make_stamp(2047, 2047, 64, 64, 1), pick_gap());
        send_command(make_read(grwa_pkg::DEPTH - 1), pick_gap());
        send_command(make_stamp(2016, 0, 3, 2, 7), pick_gap());
        send_command(make_read(GRID_COLS), pick_gap());
        send_command(make_stamp(100, 100, 0, 5, 9), pick_gap());
        send_command(make_stamp(100, 100, 5, 0, 9), pick_gap());
        send_command(make_stamp(31, 31, 2, 2, 0), pick_gap());
        send_command(make_read(0), pick_gap());
        send_command(make_stamp(0, 1024, 63, 1, 8'hAA), pick_gap());
        send_command(make_stamp(33, 65, 64, 64, 8'h55), pick_gap());
        send_command(make_stamp(0, 0, 64, 64, 255), pick_gap());
        send_command(make_read(130), pick_gap());
        send_command(make_clear(), pick_gap());
        send_command(make_read(0), pick_gap());
        send_command(make_read(GRID_COLS), pick_gap());
        send_command(make_read(grwa_pkg::DEPTH - 1), pick_gap());

        send_random_words(RANDOM_WORDS / 3);

        // hold the sink off while reads keep coming, so the block backs up
        hold_request = 400;
        for (n = 0; n < 8; n++)
            send_command(make_read($urandom_range(0, grwa_pkg::DEPTH - 1)), 0);

        no_idle = 1'b1;
        send_random_words(RANDOM_WORDS / 3);
        no_idle = 1'b0;
        send_random_words(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));

        @(negedge i_clk);
        cmd_bus.valid <= 1'b0;
        while (grid_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d clears, %0d stamps (%0d spilling past the right edge,",
                 grid_sb.clears, grid_sb.stamps, grid_sb.spilled_stamps);
        $display("%0d cut at the end of the grid), %0d reads (%0d saturated).",
                 grid_sb.clipped_stamps, grid_sb.reads, grid_sb.saturated_reads);
        $display("%0d results checked, %0d mismatches.",
                 grid_sb.results_checked, grid_sb.mismatches);
        if (grid_sb.mismatches == 0)
            $display("grid_rect_weight_accumulate_unit test passed");
        else
            $display("grid_rect_weight_accumulate_unit test failed");
        $finish;
    end
endmodule

@@ sim.f @@
sv/grwa_pkg.sv
sv/grwa_if.sv
sv/grwa_div.sv
sv/grwa_grid.sv
sv/grid_rect_weight_accumulate_unit.sv
verif/tb.sv
